/* rtl/rmts_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package rmts_pkg;

   // Largest task count the register map holds
   localparam int MAX_TASKS        = 4;
   localparam int DATA_WIDTH       = 10;
   localparam int TASK_INDEX_WIDTH = 2;
   localparam int CSR_INDEX_WIDTH  = 4;

   // Register map groups, taken from the upper bits of the register index
   localparam logic [1:0] CSR_GROUP_PERIOD = 2'd0;
   localparam logic [1:0] CSR_GROUP_BURST  = 2'd1;

   localparam logic [DATA_WIDTH-1:0] PERIOD_RESET = 10'd1;
   localparam logic [DATA_WIDTH-1:0] BURST_RESET  = 10'd0;

   typedef logic [DATA_WIDTH-1:0] data_type;

   // Configuration seen by the task engine
   typedef struct packed {
      logic [MAX_TASKS-1:0][DATA_WIDTH-1:0] period;
      logic [MAX_TASKS-1:0][DATA_WIDTH-1:0] burst;
   } cfg_type;

   // One scheduling decision
   typedef struct packed {
      logic                        busy_res;
      logic [TASK_INDEX_WIDTH-1:0] task_index;
      logic [MAX_TASKS-1:0]        release_mask;
   } result_type;

endpackage

`default_nettype wire

/* rtl/rmts_channels.sv */
`timescale 1ns / 1ps
`default_nettype none

// Tick request channel
interface rmts_req_if;
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

// Scheduling result channel
interface rmts_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic                                  busy_res;
   logic [rmts_pkg::TASK_INDEX_WIDTH-1:0] task_index;
   logic [rmts_pkg::MAX_TASKS-1:0]        release_mask;

   modport source (output valid, output busy_res, output task_index, output release_mask,
                   input ready);
   modport sink   (input valid, input busy_res, input task_index, input release_mask,
                   output ready);
endinterface

`default_nettype wire

/* rtl/rate_monotonic_tick_scheduler_top.sv */
// Rate-monotonic tick scheduler. Each word on the request channel is one system tick;
// each tick yields exactly one result word telling whether a task ran, which one, and
// which tasks released a new job on that tick. Every task has a period and a burst
// register (indexes 0..3 and 4..7); a burst of zero disables the task and a period of
// zero acts as one. The shortest period with work left wins, ties to the lower index.
// A tick with restart set clears all phases and leftover work first. Throughput is one
// tick per clock while the result channel is ready; a tick passes through one input
// register, then the combinational task compare over all tasks into the output
// register. Write the registers only while no tick is in flight.
`timescale 1ns / 1ps
`default_nettype none

module rate_monotonic_tick_scheduler_top #(
   parameter int NUM_TASKS = 4
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   rmts_req_if.sink                                  req_ch,
   rmts_rsp_if.source                                rsp_ch,
   input  wire logic                                 csr_write_enable,
   input  wire logic [rmts_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [rmts_pkg::DATA_WIDTH-1:0]      csr_write_data
);

   rmts_pkg::cfg_type    cfg;
   rmts_pkg::result_type decision;

   logic                 s1_valid_ff;
   logic                 s1_valid_in;
   logic                 s1_restart_ff;
   logic                 out_valid_ff;
   logic                 out_valid_in;
   rmts_pkg::result_type out_result_ff;
   logic                 advance;
   logic                 req_take;

   rmts_cfg_regs u_cfg_regs (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   rmts_task_engine #(
      .NUM_TASKS (NUM_TASKS)
   ) u_task_engine (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .restart (s1_restart_ff),
      .cfg     (cfg),
      .result  (decision)
   );

   // Move the held tick into the output register when that register frees up
   assign advance      = s1_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !s1_valid_ff || advance;
   assign req_take     = req_ch.valid && req_ch.ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ch.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_restart_ff <= req_ch.restart;
      end
      if (advance) begin
         out_result_ff <= decision;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.busy_res     = out_result_ff.busy_res;
   assign rsp_ch.task_index   = out_result_ff.task_index;
   assign rsp_ch.release_mask = out_result_ff.release_mask;

   // An idle result reports task zero
   a_idle_index_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !out_result_ff.busy_res) |-> (out_result_ff.task_index == '0))
      else $error("idle result carries a nonzero task index");

   // A taken word is held in the input register on the next cycle
   a_take_fills_s1: assert property (@(posedge clock) disable iff (reset)
      req_take |=> s1_valid_ff)
      else $error("accepted word lost from input register");

   // Each computed tick shows up on the result channel
   a_advance_fills_out: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("computed tick missing from output register");

   // Tasks beyond the configured count never release
   a_mask_in_range: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> ((out_result_ff.release_mask >> NUM_TASKS) == '0))
      else $error("release mask bit set above task count");

endmodule

`default_nettype wire

/* rtl/rmts_cfg_regs.sv */
`timescale 1ns / 1ps
`default_nettype none

module rmts_cfg_regs (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 csr_write_enable,
   input  wire logic [rmts_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [rmts_pkg::DATA_WIDTH-1:0]      csr_write_data,
   output rmts_pkg::cfg_type                         cfg
);

   rmts_pkg::cfg_type cfg_ff;
   rmts_pkg::cfg_type cfg_in;

   // Decode the write: low bits pick the task, upper bits pick the group
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index[rmts_pkg::CSR_INDEX_WIDTH-1:2])
            rmts_pkg::CSR_GROUP_PERIOD: cfg_in.period[csr_index[1:0]] = csr_write_data;
            rmts_pkg::CSR_GROUP_BURST:  cfg_in.burst[csr_index[1:0]]  = csr_write_data;
            default: ;  // drop writes outside the map
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < rmts_pkg::MAX_TASKS; i++) begin
            cfg_ff.period[i] <= rmts_pkg::PERIOD_RESET;
            cfg_ff.burst[i]  <= rmts_pkg::BURST_RESET;
         end
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

/* rtl/rmts_task_engine.sv */
`timescale 1ns / 1ps
`default_nettype none

module rmts_task_engine #(
   parameter int NUM_TASKS = 4
) (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            step,
   input  wire logic            restart,
   input  wire rmts_pkg::cfg_type cfg,
   output rmts_pkg::result_type result
);

   localparam int DW = rmts_pkg::DATA_WIDTH;

   rmts_pkg::data_type phase_ff     [NUM_TASKS];
   rmts_pkg::data_type phase_in     [NUM_TASKS];
   rmts_pkg::data_type remaining_ff [NUM_TASKS];
   rmts_pkg::data_type remaining_in [NUM_TASKS];

   rmts_pkg::data_type eff_period   [NUM_TASKS];
   rmts_pkg::data_type loaded_work  [NUM_TASKS];

   logic                                  found;
   logic [rmts_pkg::TASK_INDEX_WIDTH-1:0] sel;
   rmts_pkg::data_type                    best;
   logic [rmts_pkg::MAX_TASKS-1:0]        mask;

   // Release, phase advance and shortest-period pick for one tick
   always_comb begin : tick_logic
      rmts_pkg::data_type ph;
      rmts_pkg::data_type rw;
      logic [DW:0]        ph_inc;
      found = 1'b0;
      sel   = '0;
      best  = '0;
      mask  = '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
         eff_period[i] = (cfg.period[i] == '0) ? DW'(1) : cfg.period[i];
         ph = restart ? '0 : phase_ff[i];
         rw = restart ? '0 : remaining_ff[i];
         // release a job at phase zero; a new job drops leftover work
         if (ph == '0) begin
            loaded_work[i] = cfg.burst[i];
            mask[i]        = (cfg.burst[i] != '0);
         end else begin
            loaded_work[i] = rw;
         end
         // wrap phase at the period, also when the period was lowered
         ph_inc = {1'b0, ph} + (DW+1)'(1);
         phase_in[i] = (ph_inc >= {1'b0, eff_period[i]}) ? '0 : ph_inc[DW-1:0];
         // strict compare keeps ties on the lower index
         if (loaded_work[i] != '0 && (!found || eff_period[i] < best)) begin
            found = 1'b1;
            best  = eff_period[i];
            sel   = rmts_pkg::TASK_INDEX_WIDTH'(i);
         end
      end
      // charge one tick of work to the winner
      for (int i = 0; i < NUM_TASKS; i++) begin
         if (found && sel == rmts_pkg::TASK_INDEX_WIDTH'(i)) begin
            remaining_in[i] = loaded_work[i] - DW'(1);
         end else begin
            remaining_in[i] = loaded_work[i];
         end
      end
      result.busy_res     = found;
      result.task_index   = found ? sel : '0;
      result.release_mask = mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            phase_ff[i]     <= '0;
            remaining_ff[i] <= '0;
         end
      end else if (step) begin
         for (int i = 0; i < NUM_TASKS; i++) begin
            phase_ff[i]     <= phase_in[i];
            remaining_ff[i] <= remaining_in[i];
         end
      end
   end

endmodule

`default_nettype wire
